FILE: rtl/smts_pkg.sv
// Shared types and codes for the sorted multi-timer scheduler.
// Used by smts_ctrl, smts_dp and the top level; depends on nothing.
`default_nettype none
package smts_pkg;

   localparam logic [2:0] FUNC_ADD       = 3'd0;
   localparam logic [2:0] FUNC_DEL_ID    = 3'd1;
   localparam logic [2:0] FUNC_DEL_OWNER = 3'd2;
   localparam logic [2:0] FUNC_DEL_PARAM = 3'd3;
   localparam logic [2:0] FUNC_SERVICE   = 3'd4;

   localparam logic [2:0] KIND_ADDED      = 3'd0;
   localparam logic [2:0] KIND_ADD_FAILED = 3'd1;
   localparam logic [2:0] KIND_DELETED    = 3'd2;
   localparam logic [2:0] KIND_FIRED      = 3'd3;
   localparam logic [2:0] KIND_NOTHING    = 3'd4;

   localparam logic CSR_MIN_PERIOD = 1'b0;
   localparam logic CSR_MAX_FIRES  = 1'b1;

   localparam logic [15:0] MIN_PERIOD_RESET = 16'd10;
   localparam logic [3:0]  MAX_FIRES_RESET  = 4'd5;
   localparam logic [3:0]  MAX_FIRES_CAP    = 4'd8;
   localparam logic [15:0] REPEAT_FOREVER   = 16'hFFFF;

   typedef struct packed {
      logic       load_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_order;
      logic       claim;
      logic       id_inc;
      logic       id_bump;
      logic       write_slot;
      logic       ins_do;
      logic       add_commit;
      logic       del_free;
      logic       cnt_clr;
      logic       svc_clr;
      logic       fire;
      logic       emit_en;
      logic [2:0] emit_kind;
      logic       emit_last;
      logic       emit_pend;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       owner_zero;
      logic       idx_last;
      logic       slot_free;
      logic       id_need_chk;
      logic       id_zero;
      logic       id_hit;
      logic       ins_hit;
      logic       del_hit;
      logic       svc_go;
      logic       fire_resched;
      logic       out_free;
      logic       pend;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/smts_dp.sv
// Datapath of the timer scheduler: slot table, due-order list, id counter and result register.
// Depends on smts_pkg; driven by smts_ctrl through cmd_type and reports through sts_type.
`default_nettype none
module smts_dp import smts_pkg::*; #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_period_ms,
   input  wire logic [15:0] req_repeat_limit,
   input  wire logic [31:0] req_user_param,
   input  wire logic [15:0] req_owner_tag,
   input  wire logic [31:0] req_target_id,
   input  wire logic [47:0] req_now_ms,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_timer_id,
   output logic [31:0]      rsp_fired_param,
   output logic [15:0]      rsp_fire_count,
   output logic [4:0]       rsp_deleted_count,
   output logic             rsp_last
);

   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);

   logic [2:0]  func_ff;
   logic [31:0] period_ff;
   logic [15:0] rep_ff;
   logic [31:0] param_ff;
   logic [15:0] owner_ff;
   logic [31:0] target_ff;
   logic [47:0] now_ff;
   logic [15:0] min_ff;
   logic [3:0]  maxf_ff;

   logic        valid_ff [TIMER_SLOTS];
   logic [31:0] id_mem   [TIMER_SLOTS];
   logic [31:0] prm_mem  [TIMER_SLOTS];
   logic [15:0] own_mem  [TIMER_SLOTS];
   logic [31:0] per_mem  [TIMER_SLOTS];
   logic [15:0] rep_mem  [TIMER_SLOTS];
   logic [15:0] fir_mem  [TIMER_SLOTS];
   logic [47:0] due_mem  [TIMER_SLOTS];
   logic [SLOT_W-1:0] order_ff [TIMER_SLOTS];
   logic [SLOT_W-1:0] order_in [TIMER_SLOTS];

   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] sel_ff;
   logic [SLOT_W-1:0] ins_slot_ff;
   logic [CNT_W-1:0]  active_ff;
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  del_cnt_ff;
   logic [31:0]       last_id_ff;
   logic              wrapped_ff;
   logic [47:0]       ins_due_ff;
   logic [3:0]        n_ff;
   logic              pend_ff;
   logic [31:0]       pend_id_ff;
   logic [31:0]       pend_prm_ff;
   logic [15:0]       pend_fir_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_kind_ff;
   logic [31:0]       rsp_id_ff;
   logic [31:0]       rsp_prm_ff;
   logic [15:0]       rsp_fir_ff;
   logic [4:0]        rsp_del_ff;
   logic              rsp_last_ff;

   logic [SLOT_W-1:0] rd_idx;
   logic [31:0]       cand;
   logic [15:0]       new_fires;
   logic [47:0]       resched_due;
   logic [31:0]       eff_period;
   logic [3:0]        lim;
   logic              rm_found;
   logic              rm_shift [TIMER_SLOTS];
   logic              match;

   assign rd_idx      = cmd.rd_order ? order_ff[idx_ff] : idx_ff;
   assign cand        = last_id_ff + 32'd1;
   assign new_fires   = fir_mem[rd_idx] + 16'd1;
   assign resched_due = due_mem[rd_idx] + {16'd0, per_mem[rd_idx]};
   assign eff_period  = (period_ff < {16'd0, min_ff}) ? {16'd0, min_ff} : period_ff;
   assign lim = (maxf_ff == 4'd0) ? 4'd1 : ((maxf_ff > MAX_FIRES_CAP) ? MAX_FIRES_CAP : maxf_ff);

   always_comb begin
      case (func_ff)
         FUNC_DEL_ID:    match = (target_ff != 32'd0) && (id_mem[idx_ff] == target_ff);
         FUNC_DEL_OWNER: match = (owner_ff != 16'd0) && (own_mem[idx_ff] == owner_ff);
         default:        match = (prm_mem[idx_ff] == param_ff);
      endcase
   end

   always_comb begin
      sts.func         = func_ff;
      sts.owner_zero   = (owner_ff == 16'd0);
      sts.idx_last     = (idx_ff == LAST_IDX);
      sts.slot_free    = !valid_ff[rd_idx];
      sts.id_need_chk  = (cand == 32'd0) || wrapped_ff;
      sts.id_zero      = (last_id_ff == 32'd0);
      sts.id_hit       = valid_ff[rd_idx] && (id_mem[rd_idx] == last_id_ff);
      sts.ins_hit      = (CNT_W'(idx_ff) == used_ff) || (ins_due_ff < due_mem[rd_idx]);
      sts.del_hit      = valid_ff[idx_ff] && match;
      sts.svc_go       = (n_ff < lim) && (active_ff != '0) && (due_mem[rd_idx] <= now_ff);
      sts.fire_resched = (rep_mem[rd_idx] == REPEAT_FOREVER) ||
                         ($signed({1'b0, new_fires}) < $signed({rep_mem[rd_idx][15],
                                                                 rep_mem[rd_idx]}));
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
      sts.pend         = pend_ff;
   end

   always_comb begin
      rm_found = 1'b0;
      for (int j = 0; j < TIMER_SLOTS; j++) begin
         if ((CNT_W'(j) < active_ff) && (order_ff[j] == rd_idx)) begin
            rm_found = 1'b1;
         end
         rm_shift[j] = rm_found;
      end
      for (int j = 0; j < TIMER_SLOTS; j++) begin
         order_in[j] = order_ff[j];
         if (cmd.ins_do) begin
            if (SLOT_W'(j) == idx_ff) begin
               order_in[j] = ins_slot_ff;
            end else if ((j > 0) && (SLOT_W'(j) > idx_ff)) begin
               order_in[j] = order_ff[(j > 0) ? j - 1 : 0];
            end
         end else if ((cmd.del_free || cmd.fire) && rm_shift[j] && (j + 1 < TIMER_SLOTS)) begin
            order_in[j] = order_ff[(j + 1 < TIMER_SLOTS) ? j + 1 : j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < TIMER_SLOTS; j++) begin
         order_ff[j] <= order_in[j];
      end
      if (cmd.load_req) begin
         func_ff   <= req_func;
         period_ff <= req_period_ms;
         rep_ff    <= req_repeat_limit;
         param_ff  <= req_user_param;
         owner_ff  <= req_owner_tag;
         target_ff <= req_target_id;
         now_ff    <= req_now_ms;
      end
      if (cmd.claim) begin
         sel_ff <= idx_ff;
      end
      if (cmd.write_slot) begin
         id_mem[sel_ff]  <= last_id_ff;
         prm_mem[sel_ff] <= param_ff;
         own_mem[sel_ff] <= owner_ff;
         per_mem[sel_ff] <= eff_period;
         rep_mem[sel_ff] <= rep_ff;
         fir_mem[sel_ff] <= 16'd0;
         due_mem[sel_ff] <= now_ff + {16'd0, eff_period};
         ins_due_ff      <= now_ff + {16'd0, eff_period};
         ins_slot_ff     <= sel_ff;
         used_ff         <= active_ff;
      end
      if (cmd.fire) begin
         fir_mem[rd_idx] <= new_fires;
         pend_id_ff      <= id_mem[rd_idx];
         pend_prm_ff     <= prm_mem[rd_idx];
         pend_fir_ff     <= new_fires;
         if (sts.fire_resched) begin
            due_mem[rd_idx] <= resched_due;
            ins_due_ff      <= resched_due;
            ins_slot_ff     <= rd_idx;
            used_ff         <= active_ff - CNT_W'(1);
         end
      end
      if (cmd.emit_en) begin
         rsp_kind_ff <= cmd.emit_kind;
         rsp_last_ff <= cmd.emit_last;
         rsp_id_ff   <= cmd.emit_pend ? pend_id_ff :
                        ((cmd.emit_kind == KIND_ADDED) ? last_id_ff : 32'd0);
         rsp_prm_ff  <= cmd.emit_pend ? pend_prm_ff : 32'd0;
         rsp_fir_ff  <= cmd.emit_pend ? pend_fir_ff : 16'd0;
         rsp_del_ff  <= (cmd.emit_kind == KIND_DELETED) ? 5'(del_cnt_ff) : 5'd0;
      end

      if (reset) begin
         min_ff       <= MIN_PERIOD_RESET;
         maxf_ff      <= MAX_FIRES_RESET;
         active_ff    <= '0;
         last_id_ff   <= 32'd0;
         wrapped_ff   <= 1'b0;
         idx_ff       <= '0;
         del_cnt_ff   <= '0;
         n_ff         <= 4'd0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < TIMER_SLOTS; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MIN_PERIOD: min_ff  <= csr_wdata;
               CSR_MAX_FIRES:  maxf_ff <= csr_wdata[3:0];
               default:        min_ff  <= min_ff;
            endcase
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + SLOT_W'(1);
         end
         if (cmd.id_inc) begin
            last_id_ff <= cand;
            if (sts.id_need_chk) begin
               wrapped_ff <= 1'b1;
            end
         end else if (cmd.id_bump) begin
            last_id_ff <= cand;
         end
         if (cmd.write_slot) begin
            valid_ff[sel_ff] <= 1'b1;
         end
         if (cmd.add_commit) begin
            active_ff <= active_ff + CNT_W'(1);
         end
         if (cmd.cnt_clr) begin
            del_cnt_ff <= '0;
         end
         if (cmd.del_free) begin
            valid_ff[idx_ff] <= 1'b0;
            active_ff        <= active_ff - CNT_W'(1);
            del_cnt_ff       <= del_cnt_ff + CNT_W'(1);
         end
         if (cmd.svc_clr) begin
            n_ff    <= 4'd0;
            pend_ff <= 1'b0;
         end else if (cmd.fire) begin
            n_ff    <= n_ff + 4'd1;
            pend_ff <= 1'b1;
            if (!sts.fire_resched) begin
               valid_ff[rd_idx] <= 1'b0;
               active_ff        <= active_ff - CNT_W'(1);
            end
         end else if (cmd.emit_pend) begin
            pend_ff <= 1'b0;
         end
         if (cmd.emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_timer_id      = rsp_id_ff;
   assign rsp_fired_param   = rsp_prm_ff;
   assign rsp_fire_count    = rsp_fir_ff;
   assign rsp_deleted_count = rsp_del_ff;
   assign rsp_last          = rsp_last_ff;

   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff <= CNT_W'(TIMER_SLOTS))
      else $error("active count exceeds the slot table");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> sts.out_free)
      else $error("result word loaded over an unaccepted word");

   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> (n_ff < lim))
      else $error("service fired beyond its limit");

endmodule
`default_nettype wire

FILE: rtl/smts_ctrl.sv
// Sequencing state machine of the timer scheduler.
// Depends on smts_pkg; issues cmd_type to smts_dp and reads back sts_type.
`default_nettype none
module smts_ctrl import smts_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire sts_type sts,
   output cmd_type   cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_FREE     = 4'd2;
   localparam logic [3:0] S_FAIL     = 4'd3;
   localparam logic [3:0] S_IDINC    = 4'd4;
   localparam logic [3:0] S_IDCHK    = 4'd5;
   localparam logic [3:0] S_WRITE    = 4'd6;
   localparam logic [3:0] S_INS      = 4'd7;
   localparam logic [3:0] S_ADDDONE  = 4'd8;
   localparam logic [3:0] S_DEL      = 4'd9;
   localparam logic [3:0] S_DELDONE  = 4'd10;
   localparam logic [3:0] S_SVC      = 4'd11;
   localparam logic [3:0] S_FIRE     = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       ins_svc_ff, ins_svc_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      ins_svc_in = ins_svc_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.idx_clr = 1'b1;
            unique case (sts.func) inside
               FUNC_ADD: state_in = sts.owner_zero ? S_FAIL : S_FREE;
               FUNC_DEL_ID, FUNC_DEL_OWNER, FUNC_DEL_PARAM: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_DEL;
               end
               FUNC_SERVICE: begin
                  cmd.svc_clr = 1'b1;
                  state_in    = S_SVC;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FREE: begin
            if (sts.slot_free) begin
               cmd.claim = 1'b1;
               state_in  = S_IDINC;
            end else if (sts.idx_last) begin
               state_in = S_FAIL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_FAIL: begin
            if (sts.out_free) begin
               cmd.emit_en   = 1'b1;
               cmd.emit_kind = KIND_ADD_FAILED;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_IDINC: begin
            cmd.id_inc = 1'b1;
            if (sts.id_need_chk) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_IDCHK;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_IDCHK: begin
            if (sts.id_zero || sts.id_hit) begin
               cmd.id_bump = 1'b1;
               cmd.idx_clr = 1'b1;
            end else if (sts.idx_last) begin
               state_in = S_WRITE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.write_slot = 1'b1;
            cmd.idx_clr    = 1'b1;
            ins_svc_in     = 1'b0;
            state_in       = S_INS;
         end
         S_INS: begin
            cmd.rd_order = 1'b1;
            if (sts.ins_hit) begin
               cmd.ins_do  = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = ins_svc_ff ? S_SVC : S_ADDDONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_ADDDONE: begin
            if (sts.out_free) begin
               cmd.emit_en    = 1'b1;
               cmd.emit_kind  = KIND_ADDED;
               cmd.emit_last  = 1'b1;
               cmd.add_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_DEL: begin
            cmd.del_free = sts.del_hit;
            if (sts.idx_last) begin
               state_in = S_DELDONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DELDONE: begin
            if (sts.out_free) begin
               cmd.emit_en   = 1'b1;
               cmd.emit_kind = KIND_DELETED;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SVC: begin
            cmd.rd_order = 1'b1;
            if (sts.out_free) begin
               if (sts.pend) begin
                  cmd.emit_en   = 1'b1;
                  cmd.emit_pend = 1'b1;
                  cmd.emit_kind = KIND_FIRED;
                  cmd.emit_last = !sts.svc_go;
               end
               if (sts.svc_go) begin
                  state_in = S_FIRE;
               end else begin
                  if (!sts.pend) begin
                     cmd.emit_en   = 1'b1;
                     cmd.emit_kind = KIND_NOTHING;
                     cmd.emit_last = 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_FIRE: begin
            cmd.rd_order = 1'b1;
            cmd.fire     = 1'b1;
            if (sts.fire_resched) begin
               cmd.idx_clr = 1'b1;
               ins_svc_in  = 1'b1;
               state_in    = S_INS;
            end else begin
               state_in = S_SVC;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ins_svc_ff <= ins_svc_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sorted_multi_timer_scheduler.sv
// Top level of the sorted multi-timer scheduler.
// Instantiates smts_ctrl and smts_dp; depends on smts_pkg.
//
// A request word carries one operation in req_func: add a timer, delete by id, owner or
// user value, or service the queue at req_now_ms. Each request yields one result word,
// or for a service up to the fire limit of timer-fired words, the final one flagged by
// rsp_last. Unused function codes give no result.
// One request is handled at a time; req_stall is high from acceptance until the last
// result word has been loaded. The timer table is walked one slot per cycle: a delete
// visits every slot, an add scans for a free slot and then for its due-order insertion
// point, and each fire of a service may walk the due-order list to reinsert its timer.
// Once the id counter has wrapped, each add also scans the table per candidate id.
// Results sit in an output register; while rsp_stall is high the word holds and the
// sequencer waits before loading the next one.
// Reset empties the table, clears the id counter and restores min_period_ms to 10 and
// max_fires_per_service to 5. Configuration writes via csr_* are taken at any time and
// belong while the block is idle.
`default_nettype none
module sorted_multi_timer_scheduler import smts_pkg::*; #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_period_ms,
   input  wire logic [15:0] req_repeat_limit,
   input  wire logic [31:0] req_user_param,
   input  wire logic [15:0] req_owner_tag,
   input  wire logic [31:0] req_target_id,
   input  wire logic [47:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_timer_id,
   output logic [31:0]      rsp_fired_param,
   output logic [15:0]      rsp_fire_count,
   output logic [4:0]       rsp_deleted_count,
   output logic             rsp_last,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   smts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   smts_dp #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_period_ms     (req_period_ms),
      .req_repeat_limit  (req_repeat_limit),
      .req_user_param    (req_user_param),
      .req_owner_tag     (req_owner_tag),
      .req_target_id     (req_target_id),
      .req_now_ms        (req_now_ms),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_timer_id      (rsp_timer_id),
      .rsp_fired_param   (rsp_fired_param),
      .rsp_fire_count    (rsp_fire_count),
      .rsp_deleted_count (rsp_deleted_count),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

FILE: tb/timer_queue_checker.sv
// Checker for the sorted multi-timer scheduler: predicts every result word and compares.
// Watches the req_, rsp_ and csr_ ports of the block; depends on smts_pkg.
`default_nettype none
module timer_queue_checker import smts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_period_ms,
   input  wire logic [15:0] req_repeat_limit,
   input  wire logic [31:0] req_user_param,
   input  wire logic [15:0] req_owner_tag,
   input  wire logic [31:0] req_target_id,
   input  wire logic [47:0] req_now_ms,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_kind,
   input  wire logic [31:0] rsp_timer_id,
   input  wire logic [31:0] rsp_fired_param,
   input  wire logic [15:0] rsp_fire_count,
   input  wire logic [4:0]  rsp_deleted_count,
   input  wire logic        rsp_last,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               words_due
);

   localparam int SLOTS = 16;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] timer_id;
      logic [31:0] param;
      logic [15:0] count;
      logic [4:0]  deleted;
      logic        last;
   } timer_word_type;

   timer_word_type expected_words[$];
   timer_word_type item_words[$];
   int             fails;

   logic [15:0] min_period;
   logic [3:0]  fire_limit;
   logic        busy[SLOTS];
   logic [31:0] tmr_id[SLOTS];
   logic [31:0] tmr_param[SLOTS];
   logic [15:0] tmr_owner[SLOTS];
   logic [31:0] tmr_period[SLOTS];
   int          tmr_repeat[SLOTS];
   logic [15:0] tmr_fires[SLOTS];
   logic [47:0] tmr_due[SLOTS];
   int          due_queue[SLOTS];
   int          active;
   logic [31:0] last_id;
   logic        id_wrapped;

   task automatic clear_table();
      min_period = MIN_PERIOD_RESET;
      fire_limit = MAX_FIRES_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         busy[i] = 1'b0;
         due_queue[i] = 0;
      end
      active = 0;
      last_id = '0;
      id_wrapped = 1'b0;
   endtask

   task automatic unlink(int s);
      for (int i = 0; i < active; i++) begin
         if (due_queue[i] == s) begin
            for (int j = i; j + 1 < active; j++) due_queue[j] = due_queue[j + 1];
            return;
         end
      end
   endtask

   task automatic link_sorted(int s, int used);
      int pos;
      pos = used;
      for (int i = 0; i < used; i++) begin
         if (tmr_due[s] < tmr_due[due_queue[i]]) begin
            pos = i;
            break;
         end
      end
      for (int i = used; i > pos; i--) due_queue[i] = due_queue[i - 1];
      due_queue[pos] = s;
   endtask

   task automatic release_timer(int s);
      unlink(s);
      busy[s] = 1'b0;
      if (active > 0) active--;
   endtask

   function automatic logic id_taken(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (busy[i] && tmr_id[i] == id) return 1'b1;
      return 1'b0;
   endfunction

   task automatic allocate_id(output logic [31:0] id);
      last_id = last_id + 32'd1;
      if (last_id == 0 || id_wrapped) begin
         id_wrapped = 1'b1;
         while (last_id == 0 || id_taken(last_id)) last_id = last_id + 32'd1;
      end
      id = last_id;
   endtask

   task automatic emit(logic [2:0] kind, logic [31:0] id, logic [31:0] prm,
                       logic [15:0] cnt, logic [4:0] del);
      timer_word_type w;
      w.kind = kind;
      w.timer_id = id;
      w.param = prm;
      w.count = cnt;
      w.deleted = del;
      w.last = 1'b0;
      item_words.insert(item_words.size(), w);
   endtask

   task automatic predict_timer_op();
      int          s;
      int          n;
      int          lim;
      int          cnt;
      logic        hit;
      logic [31:0] per;
      logic [31:0] id;
      item_words.delete();
      case (req_func)
         FUNC_ADD: begin
            s = SLOTS;
            if (req_owner_tag != 0)
               for (int i = 0; i < SLOTS; i++)
                  if (!busy[i]) begin
                     s = i;
                     break;
                  end
            if (s >= SLOTS) begin
               emit(KIND_ADD_FAILED, 0, 0, 0, 0);
            end else begin
               per = req_period_ms;
               if (per < {16'd0, min_period}) per = {16'd0, min_period};
               allocate_id(id);
               tmr_id[s] = id;
               tmr_param[s] = req_user_param;
               tmr_owner[s] = req_owner_tag;
               tmr_period[s] = per;
               tmr_repeat[s] = int'($signed(req_repeat_limit));
               tmr_fires[s] = '0;
               tmr_due[s] = req_now_ms + per;
               link_sorted(s, active);
               busy[s] = 1'b1;
               active++;
               emit(KIND_ADDED, id, 0, 0, 0);
            end
         end
         FUNC_DEL_ID, FUNC_DEL_OWNER, FUNC_DEL_PARAM: begin
            cnt = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (busy[i]) begin
                  if (req_func == FUNC_DEL_ID)
                     hit = req_target_id != 0 && tmr_id[i] == req_target_id;
                  else if (req_func == FUNC_DEL_OWNER)
                     hit = req_owner_tag != 0 && tmr_owner[i] == req_owner_tag;
                  else
                     hit = tmr_param[i] == req_user_param;
                  if (hit) begin
                     release_timer(i);
                     cnt++;
                  end
               end
            end
            emit(KIND_DELETED, 0, 0, 0, 5'(cnt));
         end
         FUNC_SERVICE: begin
            lim = fire_limit;
            if (lim < 1) lim = 1;
            if (lim > 8) lim = 8;
            n = 0;
            while (n < lim && active > 0) begin
               s = due_queue[0];
               if (tmr_due[s] > req_now_ms) break;
               tmr_fires[s] = tmr_fires[s] + 16'd1;
               emit(KIND_FIRED, tmr_id[s], tmr_param[s], tmr_fires[s], 0);
               if (tmr_repeat[s] == -1 || int'(tmr_fires[s]) < tmr_repeat[s]) begin
                  unlink(s);
                  tmr_due[s] = tmr_due[s] + {16'd0, tmr_period[s]};
                  link_sorted(s, active - 1);
               end else begin
                  release_timer(s);
               end
               n++;
            end
            if (n == 0) emit(KIND_NOTHING, 0, 0, 0, 0);
         end
         default: ;
      endcase
      if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
      foreach (item_words[i]) expected_words.insert(expected_words.size(), item_words[i]);
   endtask

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0h, got %0h", name, exp, act);
         fails++;
      end
   endtask

   task automatic check_word();
      timer_word_type w;
      if (expected_words.size() == 0) begin
         $error("result word with nothing expected: kind %0d", rsp_kind);
         fails++;
         return;
      end
      w = expected_words[0];
      expected_words.delete(0);
      check_field("kind", 32'(w.kind), 32'(rsp_kind));
      check_field("timer_id", w.timer_id, rsp_timer_id);
      check_field("fired_param", w.param, rsp_fired_param);
      check_field("fire_count", 32'(w.count), 32'(rsp_fire_count));
      check_field("deleted_count", 32'(w.deleted), 32'(rsp_deleted_count));
      check_field("last", 32'(w.last), 32'(rsp_last));
   endtask

   initial begin
      fails = 0;
      fail_count = 0;
      words_due = 0;
      clear_table();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         expected_words.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_MIN_PERIOD) min_period = csr_wdata;
            else fire_limit = csr_wdata[3:0];
         end
         if (rsp_valid && !rsp_stall) check_word();
         if (req_valid && !req_stall) predict_timer_op();
      end
      words_due <= expected_words.size();
      fail_count <= fails;
   end

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Top of the testbench: clock, reset, request stimulus, result stalls and the verdict.
// Instantiates sorted_multi_timer_scheduler and timer_queue_checker; depends on smts_pkg.
`default_nettype none
module tb import smts_pkg::*;;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [31:0] req_period_ms;
   logic [15:0] req_repeat_limit;
   logic [31:0] req_user_param;
   logic [15:0] req_owner_tag;
   logic [31:0] req_target_id;
   logic [47:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_timer_id;
   logic [31:0] rsp_fired_param;
   logic [15:0] rsp_fire_count;
   logic [4:0]  rsp_deleted_count;
   logic        rsp_last;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          words_due;

   int          cycles;
   int          stall_left;
   int          stall_draw;
   logic        calm;
   logic [47:0] uptime;
   int          adds_sent;

   sorted_multi_timer_scheduler i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_period_ms(req_period_ms), .req_repeat_limit(req_repeat_limit),
      .req_user_param(req_user_param), .req_owner_tag(req_owner_tag),
      .req_target_id(req_target_id), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_timer_id(rsp_timer_id), .rsp_fired_param(rsp_fired_param),
      .rsp_fire_count(rsp_fire_count), .rsp_deleted_count(rsp_deleted_count),
      .rsp_last(rsp_last),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   timer_queue_checker i_checker (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = calm ? 0 : $urandom_range(0, 15);
         stall_left <= stall_draw;
         rsp_stall <= stall_draw != 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(logic [2:0] f, logic [31:0] per, logic [15:0] rep,
                            logic [31:0] prm, logic [15:0] own, logic [31:0] tgt,
                            logic [47:0] now);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_period_ms <= per;
      req_repeat_limit <= rep;
      req_user_param <= prm;
      req_owner_tag <= own;
      req_target_id <= tgt;
      req_now_ms <= now;
      if (f == FUNC_ADD) adds_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   // The block may still be busy on an ignored word when the queue drains.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_config(logic [15:0] min_per, logic [15:0] max_fires);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MIN_PERIOD;
      csr_wdata <= min_per;
      @(posedge clock);
      csr_index <= CSR_MAX_FIRES;
      csr_wdata <= max_fires;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   task automatic random_word();
      int          pick;
      logic [2:0]  f;
      logic [31:0] per;
      logic [15:0] rep;
      logic [31:0] prm;
      logic [15:0] own;
      logic [31:0] tgt;
      pick = $urandom_range(0, 99);
      if (pick < 38) f = FUNC_ADD;
      else if (pick < 78) f = FUNC_SERVICE;
      else if (pick < 85) f = FUNC_DEL_ID;
      else if (pick < 91) f = FUNC_DEL_OWNER;
      else if (pick < 97) f = FUNC_DEL_PARAM;
      else f = 3'($urandom_range(5, 7));
      per = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 120);
      rep = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6) - 1);
      prm = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 7);
      own = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
      tgt = ($urandom_range(0, 7) == 0) ? $urandom()
                                        : $urandom_range(0, adds_sent + 2);
      if ($urandom_range(0, 49) == 0) uptime = rand48();
      else uptime = uptime + 48'($urandom_range(0, 40));
      send_word(f, per, rep, prm, own, tgt, uptime);
   endtask

   initial begin
      logic [15:0] phase_min[8];
      logic [15:0] phase_fires[8];
      phase_min = '{16'd10, 16'd0, 16'd65535, 16'd1, 16'd25, 16'd0, 16'd3, 16'd10};
      phase_fires = '{16'd5, 16'd1, 16'd8, 16'd15, 16'd0, 16'd8, 16'd2, 16'd7};
      calm = 1'b0;
      adds_sent = 0;
      uptime = 48'd1000;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_ADD;
      req_period_ms <= '0;
      req_repeat_limit <= '0;
      req_user_param <= '0;
      req_owner_tag <= '0;
      req_target_id <= '0;
      req_now_ms <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_MIN_PERIOD;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset configuration.
      send_word(FUNC_ADD, 32'd50, 16'hFFFF, 32'd1, 16'd0, 0, uptime);
      send_word(FUNC_ADD, 32'd0, 16'hFFFF, 32'd1, 16'd1, 0, uptime);
      send_word(FUNC_ADD, 32'hFFFFFFFF, 16'h7FFF, 32'hFFFFFFFF, 16'hFFFF, 0, uptime);
      send_word(FUNC_ADD, 32'd5, 16'd0, 32'd2, 16'd2, 0, uptime);
      send_word(FUNC_ADD, 32'd10, 16'h8000, 32'd3, 16'd3, 0, uptime);
      send_word(FUNC_ADD, 32'd10, 16'd2, 32'd4, 16'd4, 0, uptime);
      send_word(FUNC_SERVICE, 0, 0, 0, 0, 0, uptime);
      send_word(FUNC_SERVICE, 0, 0, 0, 0, 0, uptime + 48'd10);
      send_word(FUNC_SERVICE, 0, 0, 0, 0, 0, uptime + 48'd40);
      send_word(FUNC_DEL_ID, 0, 0, 0, 0, 32'd0, uptime);
      send_word(FUNC_DEL_ID, 0, 0, 0, 0, 32'd1, uptime);
      send_word(FUNC_DEL_OWNER, 0, 0, 0, 16'd0, 0, uptime);
      send_word(FUNC_DEL_OWNER, 0, 0, 0, 16'hFFFF, 0, uptime);
      send_word(FUNC_DEL_PARAM, 0, 0, 32'hFFFFFFFF, 0, 0, uptime);
      send_word(3'd5, 0, 0, 0, 0, 0, uptime);
      send_word(3'd6, 0, 0, 0, 0, 0, uptime);
      send_word(3'd7, 0, 0, 0, 0, 0, uptime);
      send_word(FUNC_ADD, 32'd100, 16'hFFFF, 32'd9, 16'd9, 0, 48'hFFFF_FFFF_FFFF);
      send_word(FUNC_SERVICE, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
      for (int i = 0; i < 17; i++)
         send_word(FUNC_ADD, 32'd0, 16'd1, 32'(i), 16'd7, 0, 48'd0);
      send_word(FUNC_SERVICE, 0, 0, 0, 0, 0, 48'd10);
      send_word(FUNC_DEL_PARAM, 0, 0, 32'd0, 0, 0, uptime);
      send_word(FUNC_DEL_OWNER, 0, 0, 0, 16'd7, 0, uptime);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_config(phase_min[p], phase_fires[p]);
         calm = (p % 3) == 2;
         for (int k = 0; k < 45; k++) random_word();
      end

      wait_idle();
      if (fail_count == 0 && words_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
